[design/prng_ug_pkg.sv]
package prng_ug_pkg;

  // Word and counter widths.
  localparam int unsigned WordW = 32;
  localparam int unsigned CntW  = $clog2(WordW);
  localparam int unsigned FbW   = 8;

  // Generator state after reset.
  localparam logic [WordW-1:0] PadInit  = 32'hEDA4_BABA;
  localparam logic [WordW-1:0] MultInit = 32'd69;
  localparam logic [WordW-1:0] MixInit  = 32'd233;
  localparam logic [FbW-1:0]   FbInit   = 8'd0;
  localparam logic [WordW-1:0] AllOnes  = {WordW{1'b1}};

  // Rotate and shift amounts of the mixing step.
  localparam int unsigned RotPad   = 3;
  localparam int unsigned ShiftMix = 5;
  localparam int unsigned ShiftPad = 18;

  // Request codes.
  localparam logic OpRaw     = 1'b0;
  localparam logic OpUniform = 1'b1;

  // Start request into the serial divider.
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  // Status back from the serial divider.
  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quot;
    logic [WordW-1:0] rem;
  } div_stat_t;

endpackage

[design/prng_ug_if.sv]
// Request channel: one item asks for a raw word or a uniform draw.
interface prng_ug_req_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [prng_ug_pkg::WordW-1:0]    bound;

  modport source (output valid, output op, output bound, input ready);
  modport sink   (input valid, input op, input bound, output ready);
endinterface

// Response channel: one item per request.
interface prng_ug_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [prng_ug_pkg::WordW-1:0]    value;
  logic                             bad_bound;

  modport source (output valid, output value, output bad_bound, input ready);
  modport sink   (input valid, input value, input bad_bound, output ready);
endinterface

[design/prng_ug_div.sv]
// Restoring divider, one quotient bit per cycle. The divisor must be nonzero.
module prng_ug_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  prng_ug_pkg::div_req_t  req_i,
  output prng_ug_pkg::div_stat_t stat_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [prng_ug_pkg::CntW-1:0]        cnt_q;
  logic [prng_ug_pkg::WordW-1:0]       rem_q;
  logic [prng_ug_pkg::WordW-1:0]       quot_q;
  logic [prng_ug_pkg::WordW-1:0]       divisor_q;

  logic [prng_ug_pkg::WordW:0]         shifted;
  logic [prng_ug_pkg::WordW:0]         diff;
  logic                                fits;

  // Bring down the next dividend bit and try a subtraction.
  always_comb begin
    shifted = {rem_q, quot_q[prng_ug_pkg::WordW-1]};
    diff    = shifted - {1'b0, divisor_q};
    fits    = ~diff[prng_ug_pkg::WordW];
  end

  // The quotient register starts with the dividend and fills with quotient bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
      rem_q     <= '0;
      quot_q    <= '0;
      divisor_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q    <= 1'b1;
        cnt_q     <= '0;
        rem_q     <= '0;
        quot_q    <= req_i.dividend;
        divisor_q <= req_i.divisor;
      end else if (busy_q) begin
        rem_q  <= fits ? diff[prng_ug_pkg::WordW-1:0] : shifted[prng_ug_pkg::WordW-1:0];
        quot_q <= {quot_q[prng_ug_pkg::WordW-2:0], fits};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == {prng_ug_pkg::CntW{1'b1}}) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.quot = quot_q;
  assign stat_o.rem  = rem_q;

endmodule

[design/prng_uniform_generator.sv]
// Channel  Direction  Payload             Handshake
// req_i    in         op, bound           valid/ready
// rsp_o    out        value, bad_bound    valid/ready
//
// A raw request runs the serial multiplier in StDraw, one mixing step in StMix and then
// StFinish, which loads the output register. A uniform request adds a limit pass of the
// divider before the draw, a new draw for each rejected draw and a final divider pass;
// a zero bound goes from acceptance straight to StFinish.
// Reset seeds the generator words and empties the output register. A request is taken
// only while the sequencer is idle; a stalled result waits in the output register.
module prng_uniform_generator (
  input logic                clk_i,
  input logic                rst_ni,
  prng_ug_req_if.sink        req_i,
  prng_ug_rsp_if.source      rsp_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDivLim,
    StDraw,
    StMix,
    StDivOut,
    StFinish
  } state_e;

  state_e                              state_q;
  logic                                op_q;
  logic [prng_ug_pkg::CntW-1:0]        cnt_q;

  // Generator state.
  logic [prng_ug_pkg::WordW-1:0]       pad_q;
  logic [prng_ug_pkg::WordW-1:0]       mult_q;
  logic [prng_ug_pkg::WordW-1:0]       mix_q;
  logic [prng_ug_pkg::FbW-1:0]         fb_q;

  // Serial multiplier: multiplier bits shift out, multiplicand shifts up.
  logic [prng_ug_pkg::WordW-1:0]       mq_q;
  logic [prng_ug_pkg::WordW-1:0]       mc_q;
  logic [prng_ug_pkg::WordW-1:0]       acc_q;

  // Uniform draw limits and the pending result.
  logic [prng_ug_pkg::WordW-1:0]       lim_q;
  logic [prng_ug_pkg::WordW-1:0]       step_q;
  logic [prng_ug_pkg::WordW-1:0]       res_q;
  logic                                bad_q;

  logic                                out_valid_q;
  logic [prng_ug_pkg::WordW-1:0]       out_value_q;
  logic                                out_bad_q;

  logic [prng_ug_pkg::WordW-1:0]       p_sum;
  logic [prng_ug_pkg::WordW-1:0]       p_rot;
  logic [prng_ug_pkg::WordW-1:0]       mix_nx;
  logic [prng_ug_pkg::FbW-1:0]         fb_nx;
  logic [prng_ug_pkg::WordW-1:0]       draw_x;
  logic                                in_take;
  logic                                out_free;

  prng_ug_pkg::div_req_t               div_req;
  prng_ug_pkg::div_stat_t              div_stat;

  assign in_take  = req_i.valid & (state_q == StIdle);
  assign out_free = ~out_valid_q | rsp_o.ready;

  // Finish one draw from the product and the current state.
  always_comb begin
    p_sum  = pad_q + {{(prng_ug_pkg::WordW-prng_ug_pkg::FbW){1'b0}}, fb_q} + acc_q;
    p_rot  = (p_sum << prng_ug_pkg::RotPad) | (p_sum >> (prng_ug_pkg::WordW-prng_ug_pkg::RotPad));
    mix_nx = mix_q ^ {p_rot[0], p_rot[prng_ug_pkg::WordW-1:1]};
    fb_nx  = fb_q ^ p_rot[prng_ug_pkg::FbW-1:0] ^ mix_nx[2*prng_ug_pkg::FbW-1:prng_ug_pkg::FbW]
             ^ prng_ug_pkg::FbW'(1);
    draw_x = p_rot ^ (mix_nx << prng_ug_pkg::ShiftMix) ^ (p_rot >> prng_ug_pkg::ShiftPad)
             ^ {{(prng_ug_pkg::WordW-prng_ug_pkg::FbW-1){1'b0}}, fb_nx, 1'b0};
  end

  // Divider starts: limit pass for a nonzero uniform bound, scaling pass on an accepted draw.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = prng_ug_pkg::AllOnes;
    div_req.divisor  = req_i.bound;
    if (in_take && (req_i.op == prng_ug_pkg::OpUniform) && (req_i.bound != '0)) begin
      div_req.start = 1'b1;
    end else if ((state_q == StMix) && (op_q == prng_ug_pkg::OpUniform)
                 && (draw_x < lim_q)) begin
      div_req.start    = 1'b1;
      div_req.dividend = draw_x;
      div_req.divisor  = step_q;
    end
  end

  prng_ug_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat)
  );

  // Sequencer, generator state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= prng_ug_pkg::OpRaw;
      cnt_q       <= '0;
      pad_q       <= prng_ug_pkg::PadInit;
      mult_q      <= prng_ug_pkg::MultInit;
      mix_q       <= prng_ug_pkg::MixInit;
      fb_q        <= prng_ug_pkg::FbInit;
      mq_q        <= '0;
      mc_q        <= '0;
      acc_q       <= '0;
      lim_q       <= '0;
      step_q      <= '0;
      res_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_bad_q   <= 1'b0;
    end else begin
      // The finish state refills the output register itself when it is taken.
      if (out_valid_q && rsp_o.ready && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_take) begin
            op_q  <= req_i.op;
            bad_q <= 1'b0;
            if (req_i.op == prng_ug_pkg::OpRaw) begin
              cnt_q   <= '0;
              acc_q   <= '0;
              mq_q    <= mult_q;
              mc_q    <= mix_q;
              state_q <= StDraw;
            end else if (req_i.bound == '0) begin
              res_q   <= '0;
              bad_q   <= 1'b1;
              state_q <= StFinish;
            end else begin
              state_q <= StDivLim;
            end
          end
        end
        StDivLim: begin
          if (div_stat.done) begin
            // The limit is all ones less the remainder; the quotient is the step size.
            lim_q   <= ~div_stat.rem;
            step_q  <= div_stat.quot;
            cnt_q   <= '0;
            acc_q   <= '0;
            mq_q    <= mult_q;
            mc_q    <= mix_q;
            state_q <= StDraw;
          end
        end
        StDraw: begin
          if (mq_q[0]) begin
            acc_q <= acc_q + mc_q;
          end
          mq_q  <= mq_q >> 1;
          mc_q  <= mc_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == {prng_ug_pkg::CntW{1'b1}}) begin
            state_q <= StMix;
          end
        end
        StMix: begin
          pad_q  <= p_rot;
          mult_q <= p_rot | prng_ug_pkg::WordW'(2);
          mix_q  <= mix_nx;
          fb_q   <= fb_nx;
          if (op_q == prng_ug_pkg::OpRaw) begin
            res_q   <= draw_x;
            state_q <= StFinish;
          end else if (draw_x < lim_q) begin
            state_q <= StDivOut;
          end else begin
            // Rejected draw: start another one from the updated state.
            cnt_q   <= '0;
            acc_q   <= '0;
            mq_q    <= p_rot | prng_ug_pkg::WordW'(2);
            mc_q    <= mix_nx;
            state_q <= StDraw;
          end
        end
        StDivOut: begin
          if (div_stat.done) begin
            res_q   <= div_stat.quot;
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_q;
            out_bad_q   <= bad_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign req_i.ready     = (state_q == StIdle);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.value     = out_value_q;
  assign rsp_o.bad_bound = out_bad_q;

endmodule
